/* hdl/swb_pkg.sv */
// Shared constants, types and the monthly precipitation correction table
// for the soil water balance cell step unit. No dependencies.
`default_nettype none

package swb_pkg;

  localparam int FRAC_BITS_DEF = 8;

  // field widths
  localparam int W_W    = 18;  // moisture, capacity, wilting point
  localparam int KC_W   = 9;
  localparam int DAY_W  = 9;
  localparam int P_W    = 17;
  localparam int ETP_W  = 13;
  localparam int EVAP_W = 17;
  localparam int PI_W   = 18;  // corrected precipitation
  localparam int FAC_W  = 14;  // Q0.16 correction factor
  localparam int R_W    = 17;  // Q1.16 reduction factor
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // quotient bits produced by the divider cells
  localparam int Q_W     = 27;
  localparam int INT_SH  = Q_W - 16;  // dividend bits above the first cell
  localparam int REM1_W  = 36;        // remainder width of the moisture ratio

  localparam logic [R_W-1:0]    R_ONE    = 17'd65536;
  localparam logic [EVAP_W-1:0] EVAP_MAX = 17'd131071;
  localparam logic [DAY_W-1:0]  YEAR_LEN = 9'd365;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DAY    = 2'd0,
    REG_PRECIP = 2'd1,
    REG_ETP    = 2'd2,
    REG_NONE   = 2'd3
  } swb_reg_e;

  typedef struct packed {
    logic gt;    // corrected precipitation exceeds crop evaporation
    logic zero;  // reduction factor forced to zero
    logic neg;   // moisture ratio term negative
    logic sat1;  // moisture ratio term beyond quotient range
  } swb_flags_t;

  localparam logic [DAY_W-1:0] MONTH_END [12] = '{
    9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  localparam logic [FAC_W-1:0] ERR_Q16 [12] = '{
    14'd14942, 14'd15466, 14'd13107, 14'd10486, 14'd7864, 14'd6750,
    14'd6881, 14'd6750, 14'd7537, 14'd8913, 14'd10617, 14'd12386
  };

  // correction factor of the month that holds the given day
  function automatic logic [FAC_W-1:0] err_factor(input logic [DAY_W-1:0] day);
    logic [DAY_W-1:0] d;
    logic [FAC_W-1:0] f;
    logic             found;
    d = (day >= YEAR_LEN) ? day - YEAR_LEN : day;
    f = ERR_Q16[11];
    found = 1'b0;
    for (int m = 0; m < 12; m++) begin
      if (!found && d < MONTH_END[m]) begin
        f = ERR_Q16[m];
        found = 1'b1;
      end
    end
    return f;
  endfunction

endpackage

`default_nettype wire

/* hdl/swb_div_cell.sv */
// One restoring division step: a cell of the divider row.
// Depends on nothing; instantiated by the top level for both dividers.
`default_nettype none

module swb_div_cell #(
  parameter int RW = 36,
  parameter int QB = 27
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [RW-1:0] rem_i,
  input  wire logic [QB-1:0] low_i,
  input  wire logic [RW-1:0] div_i,
  input  wire logic [QB-1:0] quo_i,
  output logic      [RW-1:0] rem_o,
  output logic      [QB-1:0] low_o,
  output logic      [RW-1:0] div_o,
  output logic      [QB-1:0] quo_o
);

  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          take;
  logic [RW-1:0] rem_d;

  always_comb begin
    // bring down the next dividend bit
    trial = {rem_i, low_i[QB-1]};
    diff  = trial - {1'b0, div_i};
    take  = trial >= {1'b0, div_i};
    rem_d = take ? diff[RW-1:0] : trial[RW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      low_o <= {low_i[QB-2:0], 1'b0};
      div_o <= div_i;
      quo_o <= {quo_i[QB-2:0], take};
    end
  end

endmodule

`default_nettype wire

/* hdl/soil_water_balance_cell_step_unit.sv */
// Top level of the soil water balance cell step unit.
// Depends on swb_pkg and swb_div_cell.
`default_nettype none

// One grid cell enters per clock while in_stall_o is low; the sustained rate is
// one cell per cycle while the output is not stalled. The pipeline consists of
// the two rows of 27 divider cells (one quotient bit per cell) that form
// the moisture ratio and the evaporation ratio, plus a product stage and a
// setup stage in front and three stages behind for the reduction factor, the
// actual evaporation and the moisture limits. A one-entry skid register at the
// output lets the pipeline take a further cell while a result waits.
// Configuration writes are always taken (ready held high) and must happen
// while the unit is idle.
module soil_water_balance_cell_step_unit
  import swb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [W_W-1:0]        moisture_i,
  input  wire logic [W_W-1:0]        field_capacity_i,
  input  wire logic [W_W-1:0]        wilting_point_i,
  input  wire logic [KC_W-1:0]       crop_coeff_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [W_W-1:0]             new_moisture_o,
  output logic [EVAP_W-1:0]          actual_evap_o
);

  localparam int ETPI_W = ETP_W + KC_W - FRAC_BITS;
  localparam int REM2_W = ETPI_W + 4;
  localparam int NCELL  = Q_W;
  localparam int CMP_W  = PI_W + 1;

  // configuration registers
  logic [DAY_W-1:0] day_q;
  logic [P_W-1:0]   precip_q;
  logic [ETP_W-1:0] etp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q    <= '0;
      precip_q <= '0;
      etp_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (swb_reg_e'(cfg_index_i))
        REG_DAY:    day_q    <= cfg_data_i[DAY_W-1:0];
        REG_PRECIP: precip_q <= cfg_data_i[P_W-1:0];
        REG_ETP:    etp_q    <= cfg_data_i[ETP_W-1:0];
        default:    ;
      endcase
    end
  end

  // pipeline control: whole pipe advances while the skid register is empty
  logic skid_v_q;
  logic en;
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // stage A: products
  logic                       va_q;
  logic [PI_W-1:0]            pi_a_q;
  logic [ETPI_W-1:0]          etpi_a_q;
  logic [W_W-1:0]             w_a_q, fk_a_q, pwp_a_q;
  logic signed [2*W_W+1:0]    n1_a_q, d1_a_q;

  logic [P_W+FAC_W-1:0]       pf_prod;
  logic [ETP_W+KC_W-1:0]      ek_prod;
  logic signed [W_W:0]        dw, dfk;
  logic signed [W_W:0]        w_s, fk_s;

  always_comb begin
    pf_prod = precip_q * err_factor(day_q);
    ek_prod = etp_q * crop_coeff_i;
    w_s     = signed'({1'b0, moisture_i});
    fk_s    = signed'({1'b0, field_capacity_i});
    dw      = w_s - signed'({1'b0, wilting_point_i});
    dfk     = fk_s - signed'({1'b0, wilting_point_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pi_a_q   <= PI_W'({1'b0, precip_q}) + PI_W'(pf_prod >> 16);
      etpi_a_q <= ETPI_W'(ek_prod >> FRAC_BITS);
      w_a_q    <= moisture_i;
      fk_a_q   <= field_capacity_i;
      pwp_a_q  <= wilting_point_i;
      n1_a_q   <= dw * fk_s;
      d1_a_q   <= w_s * dfk;
    end
  end

  // stage B and divider row: index 0 is stage B, index k the output of cell k
  logic                v_q    [NCELL+1];
  logic [PI_W-1:0]     pi_s   [NCELL+1];
  logic [ETPI_W-1:0]   etpi_s [NCELL+1];
  logic [W_W-1:0]      w_sb   [NCELL+1];
  logic [W_W-1:0]      fk_sb  [NCELL+1];
  logic [W_W-1:0]      pwp_sb [NCELL+1];
  swb_flags_t          fl_s   [NCELL+1];

  logic [REM1_W-1:0]   rem1 [NCELL+1];
  logic [Q_W-1:0]      low1 [NCELL+1];
  logic [REM1_W-1:0]   div1 [NCELL+1];
  logic [Q_W-1:0]      quo1 [NCELL+1];
  logic [REM2_W-1:0]   rem2 [NCELL+1];
  logic [Q_W-1:0]      low2 [NCELL+1];
  logic [REM2_W-1:0]   div2 [NCELL+1];
  logic [Q_W-1:0]      quo2 [NCELL+1];

  logic signed [2*W_W+1:0] an_full, ad_full;
  logic [REM1_W-1:0]       an, ad;
  logic [REM2_W-1:0]       d2;
  swb_flags_t              fl_b;

  always_comb begin
    an_full   = n1_a_q[2*W_W+1] ? -n1_a_q : n1_a_q;
    ad_full   = d1_a_q[2*W_W+1] ? -d1_a_q : d1_a_q;
    an        = an_full[REM1_W-1:0];
    ad        = ad_full[REM1_W-1:0];
    d2        = REM2_W'(etpi_a_q) * REM2_W'(10);
    fl_b.gt   = CMP_W'(pi_a_q) > CMP_W'(etpi_a_q);
    fl_b.zero = (etpi_a_q == '0) || (w_a_q == '0) || (fk_a_q == '0) ||
                (pwp_a_q == fk_a_q);
    fl_b.neg  = n1_a_q[2*W_W+1] ^ d1_a_q[2*W_W+1];
    fl_b.sat1 = (an >> INT_SH) >= ad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NCELL; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= va_q;
      for (int k = 1; k <= NCELL; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pi_s[0]   <= pi_a_q;
      etpi_s[0] <= etpi_a_q;
      w_sb[0]   <= w_a_q;
      fk_sb[0]  <= fk_a_q;
      pwp_sb[0] <= pwp_a_q;
      fl_s[0]   <= fl_b;
      rem1[0]   <= an >> INT_SH;
      low1[0]   <= {an[INT_SH-1:0], 16'd0};
      div1[0]   <= ad;
      quo1[0]   <= '0;
      rem2[0]   <= REM2_W'(etp_q >> INT_SH);
      low2[0]   <= {etp_q[INT_SH-1:0], 16'd0};
      div2[0]   <= d2;
      quo2[0]   <= '0;
      // carry the cell's own fields alongside the divider row
      for (int k = 1; k <= NCELL; k++) begin
        pi_s[k]   <= pi_s[k-1];
        etpi_s[k] <= etpi_s[k-1];
        w_sb[k]   <= w_sb[k-1];
        fk_sb[k]  <= fk_sb[k-1];
        pwp_sb[k] <= pwp_sb[k-1];
        fl_s[k]   <= fl_s[k-1];
      end
    end
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    swb_div_cell #(.RW(REM1_W), .QB(Q_W)) u_ratio (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (rem1[k]),
      .low_i (low1[k]),
      .div_i (div1[k]),
      .quo_i (quo1[k]),
      .rem_o (rem1[k+1]),
      .low_o (low1[k+1]),
      .div_o (div1[k+1]),
      .quo_o (quo1[k+1])
    );
    swb_div_cell #(.RW(REM2_W), .QB(Q_W)) u_evap (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (rem2[k]),
      .low_i (low2[k]),
      .div_i (div2[k]),
      .quo_i (quo2[k]),
      .rem_o (rem2[k+1]),
      .low_o (low2[k+1]),
      .div_o (div2[k+1]),
      .quo_o (quo2[k+1])
    );
  end

  // stage C: reduction factor
  logic                vc_q;
  logic [R_W-1:0]      r_c_q;
  logic                gt_c_q;
  logic [PI_W-1:0]     pi_c_q;
  logic [ETPI_W-1:0]   etpi_c_q;
  logic [W_W-1:0]      w_c_q, fk_c_q, pwp_c_q;

  logic signed [Q_W+1:0] rsum;
  logic [R_W-1:0]        r_d;
  swb_flags_t            fl_e;

  always_comb begin
    fl_e = fl_s[NCELL];
    rsum = fl_e.neg ? signed'({2'b0, quo2[NCELL]}) - signed'({2'b0, quo1[NCELL]})
                    : signed'({2'b0, quo2[NCELL]}) + signed'({2'b0, quo1[NCELL]});
    if (fl_e.gt) begin
      r_d = R_ONE;
    end else if (fl_e.zero) begin
      r_d = '0;
    end else if (fl_e.sat1) begin
      r_d = fl_e.neg ? '0 : R_ONE;
    end else if (rsum < 0) begin
      r_d = '0;
    end else if (rsum > signed'((Q_W+2)'(R_ONE))) begin
      r_d = R_ONE;
    end else begin
      r_d = rsum[R_W-1:0];
    end
  end

  // stage D: actual evaporation
  logic                vd_q;
  logic [PI_W-1:0]     eta_d_q;
  logic [PI_W-1:0]     pi_d_q;
  logic [W_W-1:0]      w_d_q, fk_d_q, pwp_d_q;

  logic [PI_W-1:0]      gap;
  logic [PI_W+R_W-1:0]  gap_prod;
  logic [PI_W-1:0]      eta_d;

  always_comb begin
    gap      = PI_W'(etpi_c_q) - pi_c_q;
    gap_prod = gap * r_c_q;
    eta_d    = gt_c_q ? PI_W'(etpi_c_q) : pi_c_q + PI_W'(gap_prod >> 16);
  end

  // stage E: moisture limits
  logic                vo_q;
  logic [W_W-1:0]      nw_o_q;
  logic [EVAP_W-1:0]   evap_o_q;

  logic signed [W_W+1:0] nw;
  logic [W_W-1:0]        nw_lim;

  always_comb begin
    nw = signed'({2'b0, w_d_q}) + signed'({2'b0, pi_d_q}) - signed'({2'b0, eta_d_q});
    if (nw > signed'({2'b0, fk_d_q})) begin
      nw_lim = fk_d_q;
    end else if (nw < signed'({2'b0, pwp_d_q})) begin
      nw_lim = pwp_d_q;
    end else begin
      nw_lim = nw[W_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      vc_q <= v_q[NCELL];
      vd_q <= vc_q;
      vo_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_c_q    <= r_d;
      gt_c_q   <= fl_e.gt;
      pi_c_q   <= pi_s[NCELL];
      etpi_c_q <= etpi_s[NCELL];
      w_c_q    <= w_sb[NCELL];
      fk_c_q   <= fk_sb[NCELL];
      pwp_c_q  <= pwp_sb[NCELL];

      eta_d_q  <= eta_d;
      pi_d_q   <= pi_c_q;
      w_d_q    <= w_c_q;
      fk_d_q   <= fk_c_q;
      pwp_d_q  <= pwp_c_q;

      nw_o_q   <= nw_lim;
      evap_o_q <= (eta_d_q > PI_W'(EVAP_MAX)) ? EVAP_MAX : eta_d_q[EVAP_W-1:0];
    end
  end

  // skid register: hold a stalled result while the pipe moves on once
  logic [W_W-1:0]    skid_nw_q;
  logic [EVAP_W-1:0] skid_evap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (!out_stall_i) skid_v_q <= 1'b0;
    end else if (vo_q && out_stall_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q && vo_q && out_stall_i) begin
      skid_nw_q   <= nw_o_q;
      skid_evap_q <= evap_o_q;
    end
  end

  assign out_valid_o    = skid_v_q || vo_q;
  assign new_moisture_o = skid_v_q ? skid_nw_q : nw_o_q;
  assign actual_evap_o  = skid_v_q ? skid_evap_q : evap_o_q;

endmodule

`default_nettype wire

/* tb/soil_water_balance_cell_step_unit_tb.sv */
// Testbench for the soil water balance cell step unit: directed and random bursty cells
// and output stalls, checked against an in-bench predictor via a scoreboard.
// Depends on swb_pkg and the unit's RTL.
`default_nettype none

module soil_water_balance_cell_step_unit_tb;
  import swb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [W_W-1:0]    moisture;
    logic [EVAP_W-1:0] evap;
  } cell_result_t;

  // Scoreboard: holds the day's settings and the queue of predicted cells.
  class water_balance_board;
    logic [DAY_W-1:0] day;
    logic [P_W-1:0]   precip;
    logic [ETP_W-1:0] etp;
    cell_result_t     pending[$];
    int               errors;
    int               checked;

    function new();
      day = '0;
      precip = '0;
      etp = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_register(swb_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DAY:    day = data[DAY_W-1:0];
        REG_PRECIP: precip = data[P_W-1:0];
        REG_ETP:    etp = data[ETP_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_cell(logic [W_W-1:0] w_in, logic [W_W-1:0] fk_in,
                            logic [W_W-1:0] pwp_in, logic [KC_W-1:0] kc_in);
      longint w, fk, pwp, p, e, pi_c, etpi, r, eta, nw, n1, d1;
      int d, m;
      cell_result_t res;
      w = w_in;
      fk = fk_in;
      pwp = pwp_in;
      p = precip;
      e = etp;
      d = day % 365;
      m = 0;
      while (m < 11 && d >= MONTH_END[m]) m++;
      pi_c = p + ((p * ERR_Q16[m]) >> 16);
      etpi = (e * kc_in) >> FRAC;
      if (pi_c > etpi) begin
        r = 65536;
      end else if (etpi == 0 || w == 0 || fk == 0 || pwp == fk) begin
        r = 0;
      end else begin
        n1 = (w - pwp) * fk;
        d1 = w * (fk - pwp);
        if (d1 < 0) begin
          n1 = -n1;
          d1 = -d1;
        end
        r = (n1 * 65536) / d1 + (e * 65536) / (10 * etpi);
        if (r > 65536) r = 65536;
        else if (r < 0) r = 0;
      end
      if (pi_c > etpi) eta = etpi;
      else eta = pi_c + (((etpi - pi_c) * r) >> 16);
      nw = w + pi_c - eta;
      if (nw > fk) nw = fk;
      else if (nw < pwp) nw = pwp;
      res.moisture = nw[W_W-1:0];
      res.evap = (eta > 131071) ? EVAP_MAX : eta[EVAP_W-1:0];
      pending.push_back(res);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_cell(logic [W_W-1:0] nw, logic [EVAP_W-1:0] eta);
      cell_result_t want;
      if (pending.size() == 0) begin
        report("unexpected result, moisture", nw, 0);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (nw !== want.moisture) report("new_moisture", nw, want.moisture);
      if (eta !== want.evap) report("actual_evap", eta, want.evap);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [W_W-1:0] moisture_i = '0;
  logic [W_W-1:0] field_capacity_i = '0;
  logic [W_W-1:0] wilting_point_i = '0;
  logic [KC_W-1:0] crop_coeff_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [W_W-1:0] new_moisture_o;
  logic [EVAP_W-1:0] actual_evap_o;

  water_balance_board board = new();
  int cycles = 0;
  int burst_left = 0;
  bit stall_busy = 1'b0;
  int stall_left = 0;

  soil_water_balance_cell_step_unit u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .moisture_i, .field_capacity_i, .wilting_point_i,
    .crop_coeff_i, .out_valid_o, .out_stall_i, .new_moisture_o, .actual_evap_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_cell(new_moisture_o, actual_evap_o);
  end

  // Receiver stalls in modes: clear stretches and stretches that stall at random.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(5, 60);
      stall_busy = ($urandom_range(0, 3) != 0);
    end
    stall_left--;
    out_stall_i <= stall_busy ? ($urandom_range(0, 99) < 40) : 1'b0;
  end

  task automatic write_register(swb_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_day(logic [DAY_W-1:0] d, logic [P_W-1:0] p, logic [ETP_W-1:0] e);
    write_register(REG_DAY, CFG_DATA_W'(d));
    write_register(REG_PRECIP, CFG_DATA_W'(p));
    write_register(REG_ETP, CFG_DATA_W'(e));
  endtask

  // Called on a falling edge; returns on the falling edge after the transfer.
  task automatic send_cell(logic [W_W-1:0] w, logic [W_W-1:0] fk,
                           logic [W_W-1:0] pwp, logic [KC_W-1:0] kc);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    moisture_i <= w;
    field_capacity_i <= fk;
    wilting_point_i <= pwp;
    crop_coeff_i <= kc;
    do @(posedge clk_i); while (in_stall_o);
    board.note_cell(w, fk, pwp, kc);
    @(negedge clk_i);
  endtask

  task automatic random_cell();
    logic [W_W-1:0] w, fk, pwp;
    logic [KC_W-1:0] kc;
    int mode;
    mode = $urandom_range(0, 9);
    kc = KC_W'($urandom_range(0, 511));
    if (mode < 7) begin
      fk = W_W'($urandom_range(1, 262143));
      pwp = W_W'($urandom_range(0, fk - 1));
      w = W_W'($urandom_range(0, 262143) % (fk + 1));
    end else begin
      w = W_W'($urandom);
      fk = W_W'($urandom);
      pwp = W_W'($urandom);
      case ($urandom_range(0, 4))
        0: pwp = fk;
        1: w = '0;
        2: fk = '0;
        default: ;
      endcase
    end
    send_cell(w, fk, pwp, kc);
  endtask

  // Called on a falling edge; let results drain before settings change.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (board.pending.size() != 0 && cycles < CYCLE_LIMIT) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    logic [P_W-1:0] p;
    int sent;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reduction factor branches, zero cases, extremes.
    set_day(9'd0, '0, 13'd8191);
    send_cell(18'd1000, 18'd2000, 18'd500, 9'd256);
    send_cell('0, 18'd2000, 18'd500, 9'd256);
    send_cell(18'd1000, '0, 18'd500, 9'd256);
    send_cell(18'd1000, 18'd2000, 18'd2000, 9'd256);
    send_cell(18'd1000, 18'd2000, 18'd3000, 9'd256);
    send_cell(18'd100000, 18'd2000, 18'd100, 9'd511);
    send_cell('1, '1, '0, 9'd511);
    send_cell('1, '1, '1, '0);
    send_cell(18'd5, 18'd262143, 18'd262142, 9'd1);
    drain();
    set_day(9'd364, 17'd131071, '0);
    write_register(REG_NONE, '1);
    send_cell('0, '0, '0, '0);
    send_cell('1, 18'd1000, 18'd10, 9'd511);
    send_cell(18'd10, 18'd1000, 18'd500, 9'd100);
    send_cell(18'd1000, 18'd10, 18'd5000, 9'd3);
    drain();
    set_day(9'd511, 17'd3000, 13'd4000);
    send_cell(18'd40000, 18'd60000, 18'd20000, 9'd200);
    send_cell(18'd20000, 18'd60000, 18'd25000, 9'd400);
    send_cell(18'd1, 18'd60000, 18'd0, 9'd511);
    send_cell(18'd70000, 18'd60000, 18'd30000, 9'd300);
    drain();

    // Random days: mostly small precipitation so both branches of R occur.
    sent = 0;
    while (sent < 1600) begin
      p = ($urandom_range(0, 3) == 0) ? P_W'($urandom) : P_W'($urandom_range(0, 16000));
      set_day(DAY_W'($urandom), p, ETP_W'($urandom));
      repeat ($urandom_range(60, 140)) begin
        random_cell();
        sent++;
      end
      drain();
    end

    $display("covered %0d cells over many day settings, %0d mismatches",
             board.checked, board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hdl/swb_pkg.sv
hdl/swb_div_cell.sv
hdl/soil_water_balance_cell_step_unit.sv
tb/soil_water_balance_cell_step_unit_tb.sv
